// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sub-segment minimum block.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define SMF_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SMF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/smf_pkg.sv =====
// Types and constants shared by the sub-segment minimum feature block.
// No dependencies.
package smf_pkg;

	localparam int SIZE_W   = 11;
	localparam int IDX_W    = 2;
	localparam int TOT_W    = 3;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;
	// reciprocal shift for the divide by the feature count
	localparam int RECIP_SH = 16;
	localparam int RECIP_W  = 17;

	// one classified fingerprint on its way from front to back
	typedef struct packed {
		logic [63:0]       fp_high;
		logic [63:0]       fp_middle;
		logic [31:0]       fp_low;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] sub_len;
		logic [SIZE_W-1:0] last_len;
		logic              pass;
	} smf_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} smf_qstat_t;

endpackage

// ===== hdl/smf_front.sv =====
// Front end: takes fingerprint beats, clamps the segment size and works out
// the sub-segment lengths over two stages. Depends on smf_pkg.
module smf_front import smf_pkg::*; #(
	parameter int FEATURE_COUNT = 4,
	parameter int MAX_SEGMENT   = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fp_valid,
	output logic              fp_stall,
	input  logic [63:0]       fp_high,
	input  logic [63:0]       fp_middle,
	input  logic [31:0]       fp_low,
	input  logic [SIZE_W-1:0] segment_size,
	input  smf_qstat_t        q_stat,
	output logic              q_push,
	output smf_item_t         q_item
);

	localparam int SEG_LIM = (MAX_SEGMENT < 2047) ? MAX_SEGMENT : 2047;
	localparam int PROD_W  = SIZE_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / FEATURE_COUNT);
	localparam logic [SIZE_W-1:0]  FC_S  = SIZE_W'(FEATURE_COUNT);
	localparam logic [SIZE_W-1:0]  LIM_S = SIZE_W'(SEG_LIM);

	logic              advance;
	logic              valid_s1;
	logic [63:0]       high_s1;
	logic [63:0]       middle_s1;
	logic [31:0]       low_s1;
	logic [SIZE_W-1:0] size_s1;
	logic              pass_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              valid_s2;
	smf_item_t         item_s2;

	logic [SIZE_W-1:0] size_c;
	logic [SIZE_W-1:0] quot0;
	logic [SIZE_W-1:0] rem0;
	logic              fix;
	logic [SIZE_W-1:0] sub_len;
	logic [SIZE_W-1:0] rem;

	assign advance  = !(valid_s2 && q_stat.full);
	assign fp_stall = !advance;
	assign q_push   = valid_s2 && !q_stat.full;
	assign q_item   = item_s2;

	always_comb begin
		if (segment_size == '0) begin
			size_c = SIZE_W'(1);
		end else if (segment_size > LIM_S) begin
			size_c = LIM_S;
		end else begin
			size_c = segment_size;
		end
	end

	// reciprocal quotient may come out one short; one correction fixes it
	always_comb begin
		quot0   = prod_s1[RECIP_SH +: SIZE_W];
		rem0    = size_s1 - SIZE_W'(quot0 * FC_S);
		fix     = (rem0 >= FC_S);
		sub_len = quot0 + SIZE_W'(fix);
		rem     = fix ? (rem0 - FC_S) : rem0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= fp_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			high_s1   <= fp_high;
			middle_s1 <= fp_middle;
			low_s1    <= fp_low;
			size_s1   <= size_c;
			pass_s1   <= (size_c <= FC_S);
			prod_s1   <= PROD_W'(size_c) * PROD_W'(RECIP);
			item_s2.fp_high   <= high_s1;
			item_s2.fp_middle <= middle_s1;
			item_s2.fp_low    <= low_s1;
			item_s2.size      <= size_s1;
			item_s2.sub_len   <= sub_len;
			// size - (count-1)*sub equals remainder + sub
			item_s2.last_len  <= rem + sub_len;
			item_s2.pass      <= pass_s1;
		end
	end

endmodule

// ===== hdl/smf_queue.sv =====
// Short queue between the front end and the back end.
// Depends on smf_pkg.
module smf_queue import smf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  smf_item_t  push_item,
	input  logic       pop,
	output smf_item_t  head_item,
	output smf_qstat_t stat
);

	smf_item_t         slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/smf_back.sv =====
// Back end: segment and sub-segment tracking, running minimum and the
// feature output register. Depends on smf_pkg.
module smf_back import smf_pkg::*; #(
	parameter int FEATURE_COUNT = 4,
	parameter int MAX_SEGMENT   = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  smf_item_t        item,
	input  smf_qstat_t       q_stat,
	output logic             q_pop,
	output logic             feat_valid,
	input  logic             feat_stall,
	output logic [63:0]      feat_high,
	output logic [63:0]      feat_middle,
	output logic [31:0]      feat_low,
	output logic [IDX_W-1:0] feature_index,
	output logic [TOT_W-1:0] feature_total,
	output logic             last_feature
);

	localparam int SEG_LIM = (MAX_SEGMENT < 2047) ? MAX_SEGMENT : 2047;
	localparam int ITEM_W  = $clog2(FEATURE_COUNT * SEG_LIM + 1);
	localparam int PP_W    = $clog2(SEG_LIM + 1);
	localparam int PI_W    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int CMP_W   = ((ITEM_W > SIZE_W) ? ITEM_W : SIZE_W) + 1;
	localparam int PLW     = SIZE_W + 1;
	localparam logic [PI_W-1:0]  PI_LAST = PI_W'(FEATURE_COUNT - 1);
	localparam logic [TOT_W-1:0] TOTAL   = TOT_W'(FEATURE_COUNT);

	logic [ITEM_W-1:0] item_pos_q;
	logic [PI_W-1:0]   part_idx_q;
	logic [PP_W-1:0]   part_pos_q;
	logic [63:0]       best_high_q;
	logic [63:0]       best_middle_q;
	logic [31:0]       best_low_q;
	logic              out_valid_q;

	logic              take;
	logic [63:0]       nb_high;
	logic [63:0]       nb_middle;
	logic [31:0]       nb_low;
	logic [SIZE_W-1:0] plen;
	logic              part_end;
	logic              part_last;
	logic              pass_last;
	logic              emit;

	assign q_pop      = !q_stat.empty && (!out_valid_q || !feat_stall);
	assign feat_valid = out_valid_q;

	always_comb begin
		take = (part_pos_q == '0) ||
			({item.fp_high, item.fp_middle, item.fp_low} <
			 {best_high_q, best_middle_q, best_low_q});
		nb_high   = take ? item.fp_high   : best_high_q;
		nb_middle = take ? item.fp_middle : best_middle_q;
		nb_low    = take ? item.fp_low    : best_low_q;
		plen      = (part_idx_q < PI_LAST) ? item.sub_len : item.last_len;
		part_end  = (PLW'(part_pos_q) + 1'b1) >= PLW'(plen);
		part_last = (part_idx_q >= PI_LAST);
		pass_last = (CMP_W'(item_pos_q) + 1'b1) >= CMP_W'(item.size);
		emit      = item.pass || part_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_pos_q  <= '0;
			part_idx_q  <= '0;
			part_pos_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= emit;
			end else if (!feat_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (item.pass) begin
					if (pass_last) begin
						item_pos_q <= '0;
						part_idx_q <= '0;
						part_pos_q <= '0;
					end else begin
						item_pos_q <= item_pos_q + 1'b1;
					end
				end else if (part_end && part_last) begin
					item_pos_q <= '0;
					part_idx_q <= '0;
					part_pos_q <= '0;
				end else if (part_end) begin
					item_pos_q <= item_pos_q + 1'b1;
					part_idx_q <= part_idx_q + 1'b1;
					part_pos_q <= '0;
				end else begin
					item_pos_q <= item_pos_q + 1'b1;
					part_pos_q <= part_pos_q + 1'b1;
				end
			end
		end
	end

	// minimum needs no clearing: a fresh sub-segment always loads its first beat
	always_ff @(posedge clk) begin
		if (q_pop && !item.pass) begin
			best_high_q   <= nb_high;
			best_middle_q <= nb_middle;
			best_low_q    <= nb_low;
		end
		if (q_pop && emit) begin
			if (item.pass) begin
				feat_high     <= item.fp_high;
				feat_middle   <= item.fp_middle;
				feat_low      <= item.fp_low;
				feature_index <= IDX_W'(item_pos_q);
				feature_total <= TOT_W'(item.size);
				last_feature  <= pass_last;
			end else begin
				feat_high     <= nb_high;
				feat_middle   <= nb_middle;
				feat_low      <= nb_low;
				feature_index <= IDX_W'(part_idx_q);
				feature_total <= TOTAL;
				last_feature  <= part_last;
			end
		end
	end

endmodule

// ===== hdl/subsegment_min_feature.sv =====
// Channel    Handshake                Payload
// fp         fp_valid / fp_stall      fp_high, fp_middle, fp_low, segment_size
// feat       feat_valid / feat_stall  feat_high, feat_middle, feat_low,
//                                     feature_index, feature_total, last_feature
//
// Sustains one fingerprint beat per cycle while feat_stall is low. The beat completing a
// feature passes the second front stage and a queue slot, and feat_valid then rises from
// the output register. The per-beat limit is the 160-bit compare with the running minimum.
// Reset clears the pipeline, the queue and all segment tracking at once.
// A stalled output holds the back end; the four-entry queue then fills and
// only then stalls the fingerprint input.
// Top level: instantiates smf_front, smf_queue and smf_back; uses smf_pkg.
`include "assert_macros.svh"

module subsegment_min_feature import smf_pkg::*; #(
	parameter int FEATURE_COUNT = 4,
	parameter int MAX_SEGMENT   = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fp_valid,
	output logic              fp_stall,
	input  logic [63:0]       fp_high,
	input  logic [63:0]       fp_middle,
	input  logic [31:0]       fp_low,
	input  logic [SIZE_W-1:0] segment_size,
	output logic              feat_valid,
	input  logic              feat_stall,
	output logic [63:0]       feat_high,
	output logic [63:0]       feat_middle,
	output logic [31:0]       feat_low,
	output logic [IDX_W-1:0]  feature_index,
	output logic [TOT_W-1:0]  feature_total,
	output logic              last_feature
);

	smf_qstat_t q_stat;
	smf_item_t  push_item;
	smf_item_t  head_item;
	logic       q_push;
	logic       q_pop;

	smf_front #(
		.FEATURE_COUNT(FEATURE_COUNT),
		.MAX_SEGMENT  (MAX_SEGMENT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fp_valid    (fp_valid),
		.fp_stall    (fp_stall),
		.fp_high     (fp_high),
		.fp_middle   (fp_middle),
		.fp_low      (fp_low),
		.segment_size(segment_size),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	smf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.pop      (q_pop),
		.head_item(head_item),
		.stat     (q_stat)
	);

	smf_back #(
		.FEATURE_COUNT(FEATURE_COUNT),
		.MAX_SEGMENT  (MAX_SEGMENT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (head_item),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.feat_valid   (feat_valid),
		.feat_stall   (feat_stall),
		.feat_high    (feat_high),
		.feat_middle  (feat_middle),
		.feat_low     (feat_low),
		.feature_index(feature_index),
		.feature_total(feature_total),
		.last_feature (last_feature)
	);

	`SMF_ASSERT_NEVER(a_queue_overflow, q_push && q_stat.full, "push into full queue")
	`SMF_ASSERT_NEVER(a_queue_underflow, q_pop && q_stat.empty, "pop from empty queue")
	`SMF_ASSERT_IMP(a_hold_on_stall, feat_valid && feat_stall, !q_pop, "pop while feature held")

endmodule
